FILE: sv/x86eu_pkg.sv
// Shared types and codes for the 16-bit x86 execute unit.
package x86eu_pkg;

  // Operation kinds
  localparam logic [2:0] KIND_MOV  = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_CMP  = 3'd3;
  localparam logic [2:0] KIND_JUMP = 3'd4;

  // Jump and loop forms
  localparam logic [4:0] COND_JE     = 5'd0;
  localparam logic [4:0] COND_JNE    = 5'd1;
  localparam logic [4:0] COND_JL     = 5'd2;
  localparam logic [4:0] COND_JNL    = 5'd3;
  localparam logic [4:0] COND_JLE    = 5'd4;
  localparam logic [4:0] COND_JNLE   = 5'd5;
  localparam logic [4:0] COND_JB     = 5'd6;
  localparam logic [4:0] COND_JNB    = 5'd7;
  localparam logic [4:0] COND_JBE    = 5'd8;
  localparam logic [4:0] COND_JNBE   = 5'd9;
  localparam logic [4:0] COND_JP     = 5'd10;
  localparam logic [4:0] COND_JNP    = 5'd11;
  localparam logic [4:0] COND_JO     = 5'd12;
  localparam logic [4:0] COND_JNO    = 5'd13;
  localparam logic [4:0] COND_JS     = 5'd14;
  localparam logic [4:0] COND_JNS    = 5'd15;
  localparam logic [4:0] COND_LOOP   = 5'd16;
  localparam logic [4:0] COND_LOOPZ  = 5'd17;
  localparam logic [4:0] COND_LOOPNZ = 5'd18;
  localparam logic [4:0] COND_JCXZ   = 5'd19;

  // Operand parts
  localparam logic [1:0] PART_WORD = 2'd0;
  localparam logic [1:0] PART_LOW  = 2'd1;
  localparam logic [1:0] PART_HIGH = 2'd2;

  // Register file
  localparam int          REG_COUNT = 8;
  localparam logic [2:0]  REG_CX    = 3'd1;

  // Flag bit positions
  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 2;
  localparam int FLAG_AF = 4;
  localparam int FLAG_ZF = 6;
  localparam int FLAG_SF = 7;
  localparam int FLAG_OF = 11;
  localparam logic [11:0] FLAG_ARITH_MASK = 12'h8d5;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         condition;
    logic [2:0]         dest_reg;
    logic [1:0]         dest_part;
    logic               src_is_immediate;
    logic [2:0]         src_reg;
    logic [1:0]         src_part;
    logic [15:0]        immediate;
    logic signed [15:0] displacement;
    logic [2:0]         length;
  } instr_t;

  typedef struct packed {
    logic [15:0] dest_after;
    logic [11:0] flags_after;
    logic [15:0] ip_after;
    logic        jump_taken;
  } result_t;

endpackage

FILE: sv/x86_16_execute_unit_core.sv
// Execute unit for decoded 16-bit x86 mov/add/sub/cmp and conditional jumps.
//
//   channel   dir   handshake                   payload
//   instr     in    instr_valid / instr_stall   x86eu_pkg::instr_t
//   result    out   result_valid / result_stall x86eu_pkg::result_t
//
// One instruction per cycle sustained while results are not stalled. The taking
// edge registers the transaction and reads the register file; the execute edge
// updates flags, IP and the write-back and registers the result.
// Reset clears registers (through per-entry valid bits), flags, IP and all
// valid state. A stalled result holds the execute stage; the input register
// still takes a transaction while the execute stage is empty.
module x86_16_execute_unit_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                instr_valid,
  output logic                instr_stall,
  input  x86eu_pkg::instr_t   instr,
  output logic                result_valid,
  input  logic                result_stall,
  output x86eu_pkg::result_t  result
);

  // Input stage
  logic               s1_valid;
  x86eu_pkg::instr_t  s1;
  logic               s1_fwd_d;
  logic               s1_fwd_s;
  logic               s1_dval;
  logic               s1_sval;
  logic [15:0]        s1_fwd_data;

  // Architectural state
  logic [x86eu_pkg::REG_COUNT-1:0] vld;
  logic [11:0]                     flags;
  logic [15:0]                     ip;
  logic [15:0]                     cx;

  // Handshake and write port
  logic        advance;
  logic        exec;
  logic        load;
  logic        wr_en;
  logic [2:0]  wr_addr;
  logic [15:0] wr_data;
  logic [15:0] ram_d;
  logic [15:0] ram_s;

  // Execute datapath
  logic [15:0] d_word;
  logic [15:0] s_word;
  logic        byte_op;
  logic [15:0] mask;
  logic [15:0] d_op;
  logic [15:0] s_op;
  logic [16:0] sum;
  logic [16:0] diff;
  logic        is_add;
  logic [15:0] r;
  logic        carry;
  logic        d_sign;
  logic        s_sign;
  logic        r_sign;
  logic        ovf;
  logic [11:0] flags_arith;
  logic [15:0] ip_len;
  logic [15:0] ip_next;
  logic [15:0] cx_dec;
  logic        is_loop;
  logic [15:0] cx_eff;
  logic        taken;
  logic [11:0] flags_next;
  x86eu_pkg::result_t res_next;

  function automatic logic [15:0] part_read(input logic [15:0] v, input logic [1:0] part);
    logic [15:0] o;
    begin
      if (part == x86eu_pkg::PART_LOW) begin
        o = {8'h00, v[7:0]};
      end else if (part == x86eu_pkg::PART_HIGH) begin
        o = {8'h00, v[15:8]};
      end else begin
        o = v;
      end
      return o;
    end
  endfunction

  function automatic logic [15:0] part_write(input logic [15:0] old, input logic [15:0] val,
                                             input logic [1:0] part);
    logic [15:0] o;
    begin
      if (part == x86eu_pkg::PART_LOW) begin
        o = {old[15:8], val[7:0]};
      end else if (part == x86eu_pkg::PART_HIGH) begin
        o = {val[7:0], old[7:0]};
      end else begin
        o = val;
      end
      return o;
    end
  endfunction

  // Handshake control
  assign advance     = !result_valid || !result_stall;
  assign exec        = s1_valid && advance;
  assign instr_stall = s1_valid && !advance;
  assign load        = instr_valid && !instr_stall;

  x86eu_ram #(
    .WIDTH (16),
    .DEPTH (x86eu_pkg::REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (load),
    .raddr_a (instr.dest_reg),
    .raddr_b (instr.src_reg),
    .rdata_a (ram_d),
    .rdata_b (ram_s)
  );

  // Capture the transaction, forwarding the write made in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (load) begin
      s1          <= instr;
      s1_fwd_d    <= wr_en && (wr_addr == instr.dest_reg);
      s1_fwd_s    <= wr_en && (wr_addr == instr.src_reg);
      s1_dval     <= vld[instr.dest_reg];
      s1_sval     <= vld[instr.src_reg];
      s1_fwd_data <= wr_data;
    end
  end

  // Resolve operands: forwarded data, then stored data, else reset value
  always_comb begin
    d_word = s1_fwd_d ? s1_fwd_data : (s1_dval ? ram_d : 16'h0000);
    s_word = s1_fwd_s ? s1_fwd_data : (s1_sval ? ram_s : 16'h0000);
  end

  // Arithmetic and flags at operand size
  always_comb begin
    byte_op = (s1.dest_part == x86eu_pkg::PART_LOW) || (s1.dest_part == x86eu_pkg::PART_HIGH);
    mask    = byte_op ? 16'h00ff : 16'hffff;
    d_op    = part_read(d_word, s1.dest_part) & mask;
    s_op    = (s1.src_is_immediate ? s1.immediate : part_read(s_word, s1.src_part)) & mask;
    sum     = {1'b0, d_op} + {1'b0, s_op};
    diff    = {1'b0, d_op} - {1'b0, s_op};
    is_add  = (s1.kind == x86eu_pkg::KIND_ADD);
    r       = (is_add ? sum[15:0] : diff[15:0]) & mask;
    if (is_add) begin
      carry = byte_op ? sum[8] : sum[16];
    end else begin
      carry = diff[16];
    end
    d_sign = byte_op ? d_op[7] : d_op[15];
    s_sign = byte_op ? s_op[7] : s_op[15];
    r_sign = byte_op ? r[7] : r[15];
    ovf    = is_add ? ((d_sign == s_sign) && (d_sign != r_sign))
                    : ((d_sign != s_sign) && (d_sign != r_sign));
    flags_arith = flags & ~x86eu_pkg::FLAG_ARITH_MASK;
    flags_arith[x86eu_pkg::FLAG_CF] = carry;
    flags_arith[x86eu_pkg::FLAG_PF] = ~^r[7:0];
    flags_arith[x86eu_pkg::FLAG_AF] = d_op[4] ^ s_op[4] ^ r[4];
    flags_arith[x86eu_pkg::FLAG_ZF] = (r == 16'h0000);
    flags_arith[x86eu_pkg::FLAG_SF] = r_sign;
    flags_arith[x86eu_pkg::FLAG_OF] = ovf;
  end

  // Branch condition; loop forms see CX after the decrement
  always_comb begin
    ip_len  = ip + {13'b0, s1.length};
    cx_dec  = cx - 16'h0001;
    is_loop = (s1.condition == x86eu_pkg::COND_LOOP) ||
              (s1.condition == x86eu_pkg::COND_LOOPZ) ||
              (s1.condition == x86eu_pkg::COND_LOOPNZ);
    cx_eff  = is_loop ? cx_dec : cx;
    unique case (s1.condition)
      x86eu_pkg::COND_JE:     taken = flags[x86eu_pkg::FLAG_ZF];
      x86eu_pkg::COND_JNE:    taken = !flags[x86eu_pkg::FLAG_ZF];
      x86eu_pkg::COND_JL:     taken = flags[x86eu_pkg::FLAG_SF] != flags[x86eu_pkg::FLAG_OF];
      x86eu_pkg::COND_JNL:    taken = flags[x86eu_pkg::FLAG_SF] == flags[x86eu_pkg::FLAG_OF];
      x86eu_pkg::COND_JLE:    taken = flags[x86eu_pkg::FLAG_ZF] ||
                                      (flags[x86eu_pkg::FLAG_SF] != flags[x86eu_pkg::FLAG_OF]);
      x86eu_pkg::COND_JNLE:   taken = !(flags[x86eu_pkg::FLAG_ZF] ||
                                      (flags[x86eu_pkg::FLAG_SF] != flags[x86eu_pkg::FLAG_OF]));
      x86eu_pkg::COND_JB:     taken = flags[x86eu_pkg::FLAG_CF];
      x86eu_pkg::COND_JNB:    taken = !flags[x86eu_pkg::FLAG_CF];
      x86eu_pkg::COND_JBE:    taken = flags[x86eu_pkg::FLAG_CF] || flags[x86eu_pkg::FLAG_ZF];
      x86eu_pkg::COND_JNBE:   taken = !(flags[x86eu_pkg::FLAG_CF] || flags[x86eu_pkg::FLAG_ZF]);
      x86eu_pkg::COND_JP:     taken = flags[x86eu_pkg::FLAG_PF];
      x86eu_pkg::COND_JNP:    taken = !flags[x86eu_pkg::FLAG_PF];
      x86eu_pkg::COND_JO:     taken = flags[x86eu_pkg::FLAG_OF];
      x86eu_pkg::COND_JNO:    taken = !flags[x86eu_pkg::FLAG_OF];
      x86eu_pkg::COND_JS:     taken = flags[x86eu_pkg::FLAG_SF];
      x86eu_pkg::COND_JNS:    taken = !flags[x86eu_pkg::FLAG_SF];
      x86eu_pkg::COND_LOOP:   taken = (cx_eff != 16'h0000);
      x86eu_pkg::COND_LOOPZ:  taken = (cx_eff != 16'h0000) && flags[x86eu_pkg::FLAG_ZF];
      x86eu_pkg::COND_LOOPNZ: taken = (cx_eff != 16'h0000) && !flags[x86eu_pkg::FLAG_ZF];
      x86eu_pkg::COND_JCXZ:   taken = (cx_eff == 16'h0000);
      default:                taken = 1'b0;
    endcase
  end

  // Select write-back, new flags and result
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = s1.dest_reg;
    wr_data    = part_write(d_word, r, s1.dest_part);
    flags_next = flags;
    ip_next    = ip_len;
    res_next.jump_taken = 1'b0;
    res_next.dest_after = d_word;
    unique case (s1.kind) inside
      x86eu_pkg::KIND_MOV: begin
        wr_en   = exec;
        wr_data = part_write(d_word, s_op, s1.dest_part);
        res_next.dest_after = wr_data;
      end
      x86eu_pkg::KIND_ADD, x86eu_pkg::KIND_SUB: begin
        wr_en      = exec;
        flags_next = flags_arith;
        res_next.dest_after = wr_data;
      end
      x86eu_pkg::KIND_CMP: begin
        flags_next = flags_arith;
      end
      x86eu_pkg::KIND_JUMP: begin
        wr_en   = exec && is_loop;
        wr_addr = x86eu_pkg::REG_CX;
        wr_data = cx_dec;
        ip_next = taken ? (ip_len + s1.displacement) : ip_len;
        res_next.jump_taken = taken;
        res_next.dest_after = ip_next;
      end
      default: begin
        ip_next = ip_len;
      end
    endcase
    res_next.flags_after = flags_next;
    res_next.ip_after    = ip_next;
  end

  // Commit state on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      flags <= '0;
      ip    <= '0;
      cx    <= '0;
    end else if (exec) begin
      flags <= flags_next;
      ip    <= ip_next;
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
        if (wr_addr == x86eu_pkg::REG_CX) begin
          cx <= wr_data;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= exec;
    end
    if (exec) begin
      result <= res_next;
    end
  end

  // Stall only ever holds a waiting instruction
  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    instr_stall |-> s1_valid)
    else $error("stall raised with no instruction held");

  // A held instruction stays until it executes
  a_held_stays: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("held instruction lost");

  // Execution always produces a result
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> result_valid)
    else $error("executed instruction gave no result");

  // CX copy tracks writes to register one
  a_cx_tracks: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (wr_addr == x86eu_pkg::REG_CX)) |=> (cx == $past(wr_data)))
    else $error("CX copy out of step with register file");

  // Only jump kinds report a taken jump
  a_taken_kind: assert property (@(posedge clk) disable iff (rst)
    (exec && res_next.jump_taken) |-> (s1.kind == x86eu_pkg::KIND_JUMP))
    else $error("jump taken on a non-jump instruction");

endmodule

FILE: sv/x86eu_ram.sv
// Generic RAM: one write port, two registered read ports.
module x86eu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads return the contents before a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
